FILE: rtl/kpa_pkg.sv
// Shared types, field widths, layout offsets and status codes of the probability accumulator.
package kpa_pkg;

    localparam int MODE_W   = 1;
    localparam int IDX_W    = 6;
    localparam int REWARD_W = 48;
    localparam int PROB_W   = 32;
    localparam int CNT_W    = 16;
    localparam int NUM_CNT  = 4;
    localparam int STATUS_W = 3;
    localparam int LEN_W    = 3;
    localparam int TDATA_W  = 152;

    // Bit offsets of the fields inside the slave and master tdata words.
    localparam int OFS_IDX    = 0;
    localparam int OFS_REWARD = OFS_IDX + IDX_W;
    localparam int OFS_PROB   = OFS_REWARD + REWARD_W;
    localparam int OFS_CNT    = OFS_PROB + PROB_W;
    localparam int PAYLOAD_W  = OFS_CNT + NUM_CNT * CNT_W;

    localparam logic [MODE_W-1:0] MODE_ACCUM = 1'b0;
    localparam logic [MODE_W-1:0] MODE_READ  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_MERGED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_READ_OK  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

    localparam logic [LEN_W-1:0] LEN_RESET = 3'd4;

    // One stored table entry.
    typedef struct packed {
        logic [NUM_CNT-1:0][CNT_W-1:0] cnt;
        logic [PROB_W-1:0]             prob;
        logic [REWARD_W-1:0]           reward;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic rd;
        logic merge;
        logic append;
        logic drop;
        logic rd_ok;
        logic rd_empty;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic match;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/kpa_dp.sv
// Datapath of the probability accumulator: item latch, entry memory, compare, add, output.
module kpa_dp #(
    parameter int MAX_ENTRIES = 64,
    parameter int MAX_VECTOR  = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [kpa_pkg::LEN_W-1:0]           i_cfg_wdata,
    input  logic [kpa_pkg::TDATA_W-1:0]         i_s_tdata,
    input  kpa_pkg::t_cmd                       i_cmd,
    input  logic [$clog2(MAX_ENTRIES)-1:0]      i_rd_addr,
    input  logic [$clog2(MAX_ENTRIES)-1:0]      i_wr_addr,
    output kpa_pkg::t_sts                       o_sts,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [kpa_pkg::TDATA_W-1:0]         o_m_tdata,
    output logic [kpa_pkg::STATUS_W-1:0]        o_m_tuser
);

    localparam int PAD_W = kpa_pkg::TDATA_W - kpa_pkg::PAYLOAD_W;

    kpa_pkg::t_entry r_mem [MAX_ENTRIES];
    kpa_pkg::t_entry r_rd_data;

    logic [kpa_pkg::LEN_W-1:0]                            r_len;
    logic [kpa_pkg::IDX_W-1:0]                            r_item_idx;
    logic [kpa_pkg::REWARD_W-1:0]                         r_item_reward;
    logic [kpa_pkg::PROB_W-1:0]                           r_item_prob;
    logic [kpa_pkg::NUM_CNT-1:0][kpa_pkg::CNT_W-1:0]      r_item_cnt;

    logic [kpa_pkg::STATUS_W-1:0] r_res_status;
    logic [kpa_pkg::IDX_W-1:0]    r_res_idx;
    kpa_pkg::t_entry              r_res_entry;

    logic                         r_out_vld;
    logic [kpa_pkg::STATUS_W-1:0] r_out_status;
    logic [kpa_pkg::IDX_W-1:0]    r_out_idx;
    kpa_pkg::t_entry              r_out_entry;

    logic [kpa_pkg::LEN_W-1:0]   eff_len;
    logic [kpa_pkg::NUM_CNT-1:0] lane_act;
    logic                        match;
    logic [kpa_pkg::PROB_W:0]    sum_wide;
    kpa_pkg::t_entry             merged_entry;
    kpa_pkg::t_entry             new_entry;

    // Out-of-range lengths are clamped into one to MAX_VECTOR.
    always_comb begin
        if (r_len == '0) begin
            eff_len = kpa_pkg::LEN_W'(1);
        end else if (r_len > kpa_pkg::LEN_W'(MAX_VECTOR)) begin
            eff_len = kpa_pkg::LEN_W'(MAX_VECTOR);
        end else begin
            eff_len = r_len;
        end
    end

    always_comb begin
        match = (r_rd_data.reward == r_item_reward);
        for (int j = 0; j < kpa_pkg::NUM_CNT; j++) begin
            lane_act[j] = (kpa_pkg::LEN_W'(j) < eff_len);
            if (lane_act[j] && (r_rd_data.cnt[j] != r_item_cnt[j])) begin
                match = 1'b0;
            end
        end
    end

    assign sum_wide = {1'b0, r_rd_data.prob} + {1'b0, r_item_prob};

    always_comb begin
        merged_entry      = r_rd_data;
        merged_entry.prob = sum_wide[kpa_pkg::PROB_W] ? '1 : sum_wide[kpa_pkg::PROB_W-1:0];
        new_entry.reward  = r_item_reward;
        new_entry.prob    = r_item_prob;
        // Inactive count lanes are stored as zero so that a later, longer key compares cleanly.
        for (int j = 0; j < kpa_pkg::NUM_CNT; j++) begin
            new_entry.cnt[j] = lane_act[j] ? r_item_cnt[j] : '0;
        end
    end

    assign o_sts.match    = match;
    assign o_sts.out_free = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= kpa_pkg::LEN_RESET;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (i_cmd.merge) begin
            r_mem[i_wr_addr] <= merged_entry;
        end else if (i_cmd.append) begin
            r_mem[i_wr_addr] <= new_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item_idx    <= i_s_tdata[kpa_pkg::OFS_IDX +: kpa_pkg::IDX_W];
            r_item_reward <= i_s_tdata[kpa_pkg::OFS_REWARD +: kpa_pkg::REWARD_W];
            r_item_prob   <= i_s_tdata[kpa_pkg::OFS_PROB +: kpa_pkg::PROB_W];
            r_item_cnt    <= i_s_tdata[kpa_pkg::OFS_CNT +: kpa_pkg::NUM_CNT * kpa_pkg::CNT_W];
        end
        if (i_cmd.merge) begin
            r_res_status <= kpa_pkg::ST_MERGED;
            r_res_idx    <= kpa_pkg::IDX_W'(i_wr_addr);
            r_res_entry  <= merged_entry;
        end else if (i_cmd.append) begin
            r_res_status <= kpa_pkg::ST_APPENDED;
            r_res_idx    <= kpa_pkg::IDX_W'(i_wr_addr);
            r_res_entry  <= new_entry;
        end else if (i_cmd.drop) begin
            r_res_status <= kpa_pkg::ST_DROPPED;
            r_res_idx    <= '0;
            r_res_entry  <= '0;
        end else if (i_cmd.rd_ok) begin
            r_res_status <= kpa_pkg::ST_READ_OK;
            r_res_idx    <= r_item_idx;
            r_res_entry  <= r_rd_data;
        end else if (i_cmd.rd_empty) begin
            r_res_status <= kpa_pkg::ST_EMPTY;
            r_res_idx    <= r_item_idx;
            r_res_entry  <= '0;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_idx    <= r_res_idx;
            r_out_entry  <= r_res_entry;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_out_entry.cnt, r_out_entry.prob,
                         r_out_entry.reward, r_out_idx};

endmodule

FILE: rtl/kpa_ctrl.sv
// Controller of the probability accumulator: sequences the table scan, reads and result hand-off.
module kpa_ctrl #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [kpa_pkg::MODE_W-1:0]          i_s_mode,
    input  logic [kpa_pkg::IDX_W-1:0]           i_s_index,
    input  kpa_pkg::t_sts                       i_sts,
    output kpa_pkg::t_cmd                       o_cmd,
    output logic [$clog2(MAX_ENTRIES)-1:0]      o_rd_addr,
    output logic [$clog2(MAX_ENTRIES)-1:0]      o_wr_addr
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int TW = $clog2(MAX_ENTRIES + 1);
    localparam int CW = (TW > kpa_pkg::IDX_W) ? TW : kpa_pkg::IDX_W;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_READ    = 3'd2;
    localparam logic [2:0] S_RD_WAIT = 3'd3;
    localparam logic [2:0] S_DONE    = 3'd4;

    logic [2:0]                r_state, n_state;
    logic [TW-1:0]             r_total, n_total;
    logic [TW-1:0]             r_scan, n_scan;
    logic                      r_cmp_vld, n_cmp_vld;
    logic [AW-1:0]             r_cmp_idx, n_cmp_idx;
    logic [kpa_pkg::IDX_W-1:0] r_ridx, n_ridx;

    // The scan is pipelined: an entry is read in one cycle and compared in the next.
    always_comb begin
        n_state    = r_state;
        n_total    = r_total;
        n_scan     = r_scan;
        n_cmp_vld  = r_cmp_vld;
        n_cmp_idx  = r_cmp_idx;
        n_ridx     = r_ridx;
        o_cmd      = '0;
        o_rd_addr  = r_scan[AW-1:0];
        o_wr_addr  = r_cmp_idx;
        o_s_tready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_scan        = '0;
                    n_cmp_vld     = 1'b0;
                    n_ridx        = i_s_index;
                    n_state       = (i_s_mode == kpa_pkg::MODE_READ) ? S_READ : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cmp_vld && i_sts.match) begin
                    o_cmd.merge = 1'b1;
                    n_cmp_vld   = 1'b0;
                    n_state     = S_DONE;
                end else if (!r_cmp_vld && (r_scan >= r_total)) begin
                    if (r_total == TW'(MAX_ENTRIES)) begin
                        o_cmd.drop = 1'b1;
                    end else begin
                        o_cmd.append = 1'b1;
                        o_wr_addr    = r_total[AW-1:0];
                        n_total      = r_total + 1'b1;
                    end
                    n_state = S_DONE;
                end else if (r_scan < r_total) begin
                    o_cmd.rd  = 1'b1;
                    n_scan    = r_scan + 1'b1;
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_scan[AW-1:0];
                end else begin
                    n_cmp_vld = 1'b0;
                end
            end
            S_READ: begin
                if (CW'(r_ridx) < CW'(r_total)) begin
                    o_cmd.rd  = 1'b1;
                    o_rd_addr = AW'(r_ridx);
                    n_state   = S_RD_WAIT;
                end else begin
                    o_cmd.rd_empty = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_RD_WAIT: begin
                o_cmd.rd_ok = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_total   <= '0;
            r_scan    <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_total   <= n_total;
            r_scan    <= n_scan;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
        r_ridx    <= n_ridx;
    end

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TW'(MAX_ENTRIES))
        else $error("entry count exceeds table depth");

    a_cmp_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> (TW'(r_cmp_idx) < r_total))
        else $error("compare of an entry that was never stored");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.merge, o_cmd.append, o_cmd.drop, o_cmd.rd_ok, o_cmd.rd_empty}))
        else $error("more than one result built in a cycle");

    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.append |=> (r_total == $past(r_total) + 1'b1))
        else $error("append did not advance the entry count");

    a_done_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.merge || o_cmd.append || o_cmd.drop || o_cmd.rd_empty || o_cmd.rd_ok)
        |=> (r_state == S_DONE))
        else $error("result built without moving to hand-off");

endmodule

FILE: rtl/keyed_probability_accumulator_unit.sv
// Read mode: the item is captured, the entry is read and registered, then the result is built and
// handed to the output register; an empty index skips the read. Accumulate: the stored entries
// are scanned through one memory read port, one entry a cycle, then merged, appended or dropped.
// One item is in work at a time; a finished result waits in the output register.
// Synchronous active-low reset clears the entry count, active_length (to 4) and output valid.
// Table contents are not cleared: only entries below the entry count are ever read.
module keyed_probability_accumulator_unit #(
    parameter int MAX_ENTRIES = 64,
    parameter int MAX_VECTOR  = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [kpa_pkg::LEN_W-1:0]     i_cfg_wdata,     // active_length
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // entry_index, key_reward, path_prob, count_a, count_b, count_c, count_d, zero pad
    input  logic [kpa_pkg::TDATA_W-1:0]   i_s_tdata,
    input  logic [kpa_pkg::MODE_W-1:0]    i_s_tuser,       // mode
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // result_index, out_reward, out_prob, out_count_a, out_count_b, out_count_c,
    // out_count_d, zero pad
    output logic [kpa_pkg::TDATA_W-1:0]   o_m_tdata,
    output logic [kpa_pkg::STATUS_W-1:0]  o_m_tuser        // status
);

    localparam int AW = $clog2(MAX_ENTRIES);

    kpa_pkg::t_cmd cmd;
    kpa_pkg::t_sts sts;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    kpa_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_mode   (i_s_tuser),
        .i_s_index  (i_s_tdata[kpa_pkg::OFS_IDX +: kpa_pkg::IDX_W]),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_rd_addr  (rd_addr),
        .o_wr_addr  (wr_addr)
    );

    kpa_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_VECTOR  (MAX_VECTOR)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .i_cmd       (cmd),
        .i_rd_addr   (rd_addr),
        .i_wr_addr   (wr_addr),
        .o_sts       (sts),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule
